// File: rtl/psetrk_pkg.sv
// shared constants and types of the pair set enter/exit tracker
package psetrk_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned ID_BITS_DEF  = 16;
  localparam int unsigned FIELD_W      = 16;

  localparam logic CMD_PAIR = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  typedef enum logic [2:0] {
    EV_DUP   = 3'd0,
    EV_CONT  = 3'd1,
    EV_ENTER = 3'd2,
    EV_FULL  = 3'd3,
    EV_EXIT  = 3'd4,
    EV_DONE  = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_CUR,
    ST_SCAN_PREV,
    ST_RESULT,
    ST_EXIT_SCAN,
    ST_EXIT_EMIT,
    ST_DONE
  } state_t;

endpackage

// File: rtl/psetrk_ram.sv
// single-port pair storage with registered read data
module psetrk_ram #(
  parameter int unsigned DEPTH = 2 * psetrk_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = 2 * psetrk_pkg::ID_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/pair_set_enter_exit_tracker.sv
// pair set enter/exit tracker: two banks of unordered id pairs in one single-port memory
//
// A register transaction (cmd 0) gives one result: duplicate, continuing, enter or
// dropped because the current table is full. It walks the current table one entry per
// cycle through the memory read port, then the previous table, then writes the new pair.
// A duplicate ends the walk at the matching entry and a full table skips the previous
// walk. The next transaction can be taken in the cycle after the result is loaded. An
// end-of-frame transaction (cmd 1) gives one exit per previous pair that no register
// transaction of this frame matched, then a done marker with last set; pairs matched
// during the frame are remembered in one flag per previous entry. A stall on the result
// side holds the result, each exit and the done marker. The memory has one port, so a
// walk reads one entry at a time. A new transaction is taken while the last result
// still waits in the output register. No clearing pass is needed after reset.
module pair_set_enter_exit_tracker #(
  parameter int unsigned CAPACITY = psetrk_pkg::CAPACITY_DEF,
  parameter int unsigned ID_BITS  = psetrk_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_id_a,
  input  logic [15:0] in_id_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_pair_a,
  output logic [15:0] out_pair_b,
  output logic        out_last
);

  localparam int unsigned IdW   = (ID_BITS < psetrk_pkg::FIELD_W) ? ID_BITS
                                                                   : psetrk_pkg::FIELD_W;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned MW    = $clog2(CAPACITY);
  localparam int unsigned Depth = 2 * CAPACITY;
  localparam int unsigned AW    = $clog2(Depth);

  psetrk_pkg::state_t state_r, state_nxt;
  psetrk_pkg::event_t ev_r, ev_nxt;
  psetrk_pkg::event_t out_event_r, out_event_nxt;

  logic [IdW-1:0]      a_r, a_nxt, b_r, b_nxt;
  logic [CW-1:0]       idx_r, idx_nxt, rd_idx_r, rd_idx_nxt;
  logic                chk_r, chk_nxt;
  logic [CW-1:0]       cur_cnt_r, cur_cnt_nxt, prev_cnt_r, prev_cnt_nxt;
  logic                bank_r, bank_nxt;
  logic [CAPACITY-1:0] matched_r, matched_nxt;
  logic                out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [15:0]         out_a_r, out_a_nxt, out_b_r, out_b_nxt;

  logic                ram_en, ram_we;
  logic [AW-1:0]       ram_addr;
  logic [2*IdW-1:0]    ram_rdata;
  logic [IdW-1:0]      rd_a, rd_b;
  logic [AW-1:0]       cur_base, prev_base;
  logic [CW-1:0]       scan_limit;
  logic                in_accept, out_free, scan_more, pair_hit, cur_full;

  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign cur_base   = bank_r ? AW'(CAPACITY) : '0;
  assign prev_base  = bank_r ? '0 : AW'(CAPACITY);
  assign scan_limit = (state_r == psetrk_pkg::ST_SCAN_CUR) ? cur_cnt_r : prev_cnt_r;
  assign scan_more  = idx_r < scan_limit;
  assign cur_full   = cur_cnt_r >= CW'(CAPACITY);
  assign rd_a       = ram_rdata[2*IdW-1:IdW];
  assign rd_b       = ram_rdata[IdW-1:0];
  // unordered compare against the entry read last cycle
  assign pair_hit   = chk_r && ((rd_a == a_r && rd_b == b_r) || (rd_a == b_r && rd_b == a_r));

  psetrk_ram #(
    .DEPTH (Depth),
    .WIDTH (2 * IdW)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({a_r, b_r}),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psetrk_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_cmd == psetrk_pkg::CMD_EOF) ? psetrk_pkg::ST_EXIT_SCAN
                                                      : psetrk_pkg::ST_SCAN_CUR;
        end
      end
      psetrk_pkg::ST_SCAN_CUR: begin
        if (pair_hit) begin
          state_nxt = psetrk_pkg::ST_RESULT;
        end else if (!scan_more && !chk_r) begin
          state_nxt = cur_full ? psetrk_pkg::ST_RESULT : psetrk_pkg::ST_SCAN_PREV;
        end
      end
      psetrk_pkg::ST_SCAN_PREV: begin
        if (pair_hit || (!scan_more && !chk_r)) begin
          state_nxt = psetrk_pkg::ST_RESULT;
        end
      end
      psetrk_pkg::ST_RESULT: begin
        if (out_free) state_nxt = psetrk_pkg::ST_IDLE;
      end
      psetrk_pkg::ST_EXIT_SCAN: begin
        if (!scan_more) begin
          state_nxt = psetrk_pkg::ST_DONE;
        end else if (!matched_r[idx_r[MW-1:0]]) begin
          state_nxt = psetrk_pkg::ST_EXIT_EMIT;
        end
      end
      psetrk_pkg::ST_EXIT_EMIT: begin
        if (out_free) state_nxt = psetrk_pkg::ST_EXIT_SCAN;
      end
      psetrk_pkg::ST_DONE: begin
        if (out_free) state_nxt = psetrk_pkg::ST_IDLE;
      end
      default: state_nxt = psetrk_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ev_nxt        = ev_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    idx_nxt       = idx_r;
    rd_idx_nxt    = rd_idx_r;
    chk_nxt       = 1'b0;
    cur_cnt_nxt   = cur_cnt_r;
    prev_cnt_nxt  = prev_cnt_r;
    bank_nxt      = bank_r;
    matched_nxt   = matched_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_event_nxt = out_event_r;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_last_nxt  = out_last_r;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = prev_base + AW'(idx_r);
    unique case (state_r)
      psetrk_pkg::ST_IDLE: begin
        if (in_accept) begin
          a_nxt   = in_id_a[IdW-1:0];
          b_nxt   = in_id_b[IdW-1:0];
          idx_nxt = '0;
        end
      end
      psetrk_pkg::ST_SCAN_CUR: begin
        ram_addr = cur_base + AW'(idx_r);
        if (pair_hit) begin
          ev_nxt = psetrk_pkg::EV_DUP;
        end else if (scan_more) begin
          ram_en     = 1'b1;
          rd_idx_nxt = idx_r;
          idx_nxt    = idx_r + 1'b1;
          chk_nxt    = 1'b1;
        end else if (!chk_r) begin
          ev_nxt  = psetrk_pkg::EV_FULL;
          idx_nxt = '0;
        end
      end
      psetrk_pkg::ST_SCAN_PREV: begin
        if (pair_hit) begin
          ev_nxt = psetrk_pkg::EV_CONT;
          matched_nxt[rd_idx_r[MW-1:0]] = 1'b1;
        end else if (scan_more) begin
          ram_en     = 1'b1;
          rd_idx_nxt = idx_r;
          idx_nxt    = idx_r + 1'b1;
          chk_nxt    = 1'b1;
        end else if (!chk_r) begin
          ev_nxt = psetrk_pkg::EV_ENTER;
        end
      end
      psetrk_pkg::ST_RESULT: begin
        ram_addr = cur_base + AW'(cur_cnt_r);
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_event_nxt = ev_r;
          out_a_nxt     = 16'(a_r);
          out_b_nxt     = 16'(b_r);
          out_last_nxt  = 1'b1;
          if (ev_r == psetrk_pkg::EV_CONT || ev_r == psetrk_pkg::EV_ENTER) begin
            ram_en      = 1'b1;
            ram_we      = 1'b1;
            cur_cnt_nxt = cur_cnt_r + 1'b1;
          end
        end
      end
      psetrk_pkg::ST_EXIT_SCAN: begin
        if (scan_more) begin
          if (matched_r[idx_r[MW-1:0]]) begin
            idx_nxt = idx_r + 1'b1;
          end else begin
            ram_en = 1'b1;
          end
        end
      end
      psetrk_pkg::ST_EXIT_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_event_nxt = psetrk_pkg::EV_EXIT;
          out_a_nxt     = 16'(rd_a);
          out_b_nxt     = 16'(rd_b);
          out_last_nxt  = 1'b0;
          idx_nxt       = idx_r + 1'b1;
        end
      end
      psetrk_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_event_nxt = psetrk_pkg::EV_DONE;
          out_a_nxt     = '0;
          out_b_nxt     = '0;
          out_last_nxt  = 1'b1;
          // current table turns into the previous one
          prev_cnt_nxt  = cur_cnt_r;
          cur_cnt_nxt   = '0;
          bank_nxt      = !bank_r;
          matched_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psetrk_pkg::ST_IDLE;
      chk_r       <= 1'b0;
      idx_r       <= '0;
      cur_cnt_r   <= '0;
      prev_cnt_r  <= '0;
      bank_r      <= 1'b0;
      matched_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_r       <= chk_nxt;
      idx_r       <= idx_nxt;
      cur_cnt_r   <= cur_cnt_nxt;
      prev_cnt_r  <= prev_cnt_nxt;
      bank_r      <= bank_nxt;
      matched_r   <= matched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r        <= ev_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    rd_idx_r    <= rd_idx_nxt;
    out_event_r <= out_event_nxt;
    out_a_r     <= out_a_nxt;
    out_b_r     <= out_b_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall      = state_r != psetrk_pkg::ST_IDLE;
  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;
  assign out_pair_a    = out_a_r;
  assign out_pair_b    = out_b_r;
  assign out_last      = out_last_r;

  a_cur_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_cnt_r <= CW'(CAPACITY))
    else $error("current count above capacity");

  a_write_only_new_pair: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == psetrk_pkg::ST_RESULT && !cur_full &&
                (ev_r == psetrk_pkg::EV_CONT || ev_r == psetrk_pkg::EV_ENTER)))
    else $error("pair store written outside a new-pair result");

  a_exit_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psetrk_pkg::ST_EXIT_EMIT) |->
      (!matched_r[idx_r[MW-1:0]] && idx_r < prev_cnt_r))
    else $error("exit reported for a matched or absent entry");

  a_frame_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psetrk_pkg::ST_DONE && out_free) |=>
      (cur_cnt_r == '0 && matched_r == '0 && bank_r != $past(bank_r)))
    else $error("frame swap incomplete");

endmodule

// File: verif/psetrk_checker.sv
// scoreboard for the pair set enter/exit tracker: predicts every result and checks it
module psetrk_checker #(
  parameter int unsigned CAPACITY = psetrk_pkg::CAPACITY_DEF,
  parameter int unsigned ID_BITS  = psetrk_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_id_a,
  input  logic [15:0] in_id_b,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_event_res,
  input  logic [15:0] out_pair_a,
  input  logic [15:0] out_pair_b,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] ID_MASK = (ID_BITS >= 16) ? 16'hFFFF : 16'hFFFF >> (16 - ID_BITS);

  typedef struct packed {
    psetrk_pkg::event_t ev;
    logic [15:0]        a;
    logic [15:0]        b;
    logic               last;
  } pair_event_t;

  // two banks of stored pairs, bank_cur selects this frame's table
  logic [15:0]  tab_a [2][CAPACITY];
  logic [15:0]  tab_b [2][CAPACITY];
  logic         bank_cur;
  int unsigned  cur_cnt;
  int unsigned  prev_cnt;
  pair_event_t  expected_events[$];
  int           mismatches = 0;

  function automatic bit bank_holds(logic bk, int unsigned cnt, logic [15:0] a, logic [15:0] b);
    for (int i = 0; i < cnt; i++) begin
      if ((tab_a[bk][i] == a && tab_b[bk][i] == b) || (tab_a[bk][i] == b && tab_b[bk][i] == a))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void queue_result(psetrk_pkg::event_t ev, logic [15:0] a,
                                       logic [15:0] b, logic last);
    pair_event_t item;
    item.ev   = ev;
    item.a    = a;
    item.b    = b;
    item.last = last;
    expected_events.insert(expected_events.size(), item);
  endfunction

  task automatic track_pair_command(logic cmd, logic [15:0] id_a, logic [15:0] id_b);
    logic [15:0]        a;
    logic [15:0]        b;
    logic               bank_prev;
    psetrk_pkg::event_t ev;
    a = id_a & ID_MASK;
    b = id_b & ID_MASK;
    bank_prev = ~bank_cur;
    if (cmd == psetrk_pkg::CMD_PAIR) begin
      // duplicate check wins over the full-table drop
      if (bank_holds(bank_cur, cur_cnt, a, b)) begin
        ev = psetrk_pkg::EV_DUP;
      end else if (cur_cnt >= CAPACITY) begin
        ev = psetrk_pkg::EV_FULL;
      end else begin
        tab_a[bank_cur][cur_cnt] = a;
        tab_b[bank_cur][cur_cnt] = b;
        cur_cnt++;
        ev = bank_holds(bank_prev, prev_cnt, a, b) ? psetrk_pkg::EV_CONT
                                                   : psetrk_pkg::EV_ENTER;
      end
      queue_result(ev, a, b, 1'b1);
    end else begin
      for (int i = 0; i < prev_cnt; i++) begin
        if (!bank_holds(bank_cur, cur_cnt, tab_a[bank_prev][i], tab_b[bank_prev][i]))
          queue_result(psetrk_pkg::EV_EXIT, tab_a[bank_prev][i], tab_b[bank_prev][i], 1'b0);
      end
      queue_result(psetrk_pkg::EV_DONE, 16'h0000, 16'h0000, 1'b1);
      prev_cnt = cur_cnt;
      cur_cnt  = 0;
      bank_cur = bank_prev;
    end
  endtask

  task automatic check_event();
    pair_event_t want;
    if (expected_events.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result event %0d pair %h/%h last %b", $time,
                 out_event_res, out_pair_a, out_pair_b, out_last);
    end else begin
      want = expected_events.pop_front();
      if (want.ev !== out_event_res || want.a !== out_pair_a || want.b !== out_pair_b ||
          want.last !== out_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch expected event %0d pair %h/%h last %b, got %0d %h/%h %b",
                   $time, want.ev, want.a, want.b, want.last,
                   out_event_res, out_pair_a, out_pair_b, out_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bank_cur = 1'b0;
      cur_cnt  = 0;
      prev_cnt = 0;
      expected_events.delete();
    end else begin
      if (out_valid && !out_stall)
        check_event();
      if (in_valid && !in_stall)
        track_pair_command(in_cmd, in_id_a, in_id_b);
    end
    fail_count <= mismatches;
    pending    <= expected_events.size();
  end

endmodule

// File: verif/tb_top.sv
// top of the pair set enter/exit tracker testbench: clock, reset, stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 330;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = psetrk_pkg::CMD_PAIR;
  logic [15:0] in_id_a = 16'h0000;
  logic [15:0] in_id_b = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [15:0] out_pair_a;
  logic [15:0] out_pair_b;
  logic        out_last;
  int          fail_count;
  int          pending;

  int          sent = 0;
  int          idle_cycles = 0;
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  logic [31:0] prev_pairs[$];
  logic [31:0] frame_pairs[$];

  initial begin
    forever #4 clk = ~clk;
  end

  pair_set_enter_exit_tracker dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_id_a      (in_id_a),
    .in_id_b      (in_id_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_event_res(out_event_res),
    .out_pair_a   (out_pair_a),
    .out_pair_b   (out_pair_b),
    .out_last     (out_last)
  );

  psetrk_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_id_a      (in_id_a),
    .in_id_b      (in_id_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_event_res(out_event_res),
    .out_pair_a   (out_pair_a),
    .out_pair_b   (out_pair_b),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("pair_set_enter_exit_tracker verification failed");
        $finish;
      end
    end
  end

  // result side: random stall before each transaction
  initial begin
    int gap;
    forever begin
      gap = out_quiet ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_item(logic cmd, logic [15:0] a, logic [15:0] b);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_id_a  <= a;
    in_id_b  <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sent++;
  endtask

  task automatic register_pair(logic [15:0] a, logic [15:0] b);
    send_item(psetrk_pkg::CMD_PAIR, a, b);
    frame_pairs.insert(frame_pairs.size(), {a, b});
  endtask

  task automatic end_frame();
    send_item(psetrk_pkg::CMD_EOF, 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
    prev_pairs = frame_pairs;
    frame_pairs.delete();
    in_quiet  = ($urandom_range(0, 3) == 0);
    out_quiet = ($urandom_range(0, 3) == 0);
  endtask

  // replay a known pair, swapped half the time
  task automatic replay_pair(logic [31:0] p);
    if ($urandom_range(0, 1))
      register_pair(p[15:0], p[31:16]);
    else
      register_pair(p[31:16], p[15:0]);
  endtask

  task automatic random_frame(bit fill);
    int          n;
    logic [15:0] base;
    if (fill) begin
      // more distinct pairs than the table holds, then a duplicate of the first, swapped half the time
      base = 16'($urandom_range(0, 65535));
      for (int i = 0; i < psetrk_pkg::CAPACITY_DEF + 3; i++)
        register_pair(base + 16'(i), 16'($urandom_range(0, 65535)));
      replay_pair(frame_pairs[0]);
    end else begin
      n = $urandom_range(0, 10);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0, 1: begin
            if (prev_pairs.size() > 0)
              replay_pair(prev_pairs[$urandom_range(0, prev_pairs.size() - 1)]);
            else
              register_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
          end
          2: begin
            if (frame_pairs.size() > 0)
              replay_pair(frame_pairs[$urandom_range(0, frame_pairs.size() - 1)]);
            else
              register_pair(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
          end
          3: register_pair(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
          default: register_pair(16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)));
        endcase
      end
    end
    end_frame();
  endtask

  initial begin
    int frame_no;
    frame_no = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first frame: extremes and duplicates either way round, no previous table
    register_pair(16'h0000, 16'h0000);
    register_pair(16'hFFFF, 16'hFFFF);
    register_pair(16'h0000, 16'hFFFF);
    register_pair(16'hFFFF, 16'h0000);
    register_pair(16'h1234, 16'hABCD);
    register_pair(16'hABCD, 16'h1234);
    register_pair(16'h0000, 16'h0000);
    end_frame();
    // continuing pairs, a new one, and exits for the rest
    register_pair(16'hFFFF, 16'h0000);
    register_pair(16'h5555, 16'hAAAA);
    register_pair(16'hABCD, 16'h1234);
    end_frame();
    // empty frame exits everything, then both tables empty
    end_frame();
    end_frame();

    while (sent < ITEM_TARGET) begin
      random_frame(frame_no == 2 || $urandom_range(0, 11) == 0);
      frame_no++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("pair_set_enter_exit_tracker verification clean");
    else
      $display("pair_set_enter_exit_tracker verification failed");
    $finish;
  end

endmodule
